// ----- hdl/stm_pkg.sv -----
// ---------------------------------------------------------------------------
// stm_pkg - shared definitions for the single typo word matcher
// Sizes, beat kinds and the beat passed from the front end to the back end.
// ---------------------------------------------------------------------------
package stm_pkg;

    localparam int MAX_LEN    = 32;
    localparam int INDEX_BITS = 16;

    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int ADDR_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CHAR_W     = 8;
    localparam int NUM_W      = 16;
    localparam int FCI_W      = 17;
    localparam int VERDICT_W  = 3;

    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic
    {
        KIND_REF_START,
        KIND_CAND
    } kind_t;

    typedef struct packed
    {
        kind_t             kind;
        logic              first;
        logic              last;
        logic              eff;
        logic [CHAR_W-1:0] t;
        logic [CHAR_W-1:0] rm;
        logic [CHAR_W-1:0] r0;
        logic [CHAR_W-1:0] rp;
        logic              in0;
        logic              inp;
        logic              inm;
        logic              len_eq;
        logic              ref_longer;
        logic              cand_longer;
        logic              ovf;
    } beat_t;

endpackage

// ----- hdl/stm_if.sv -----
// ---------------------------------------------------------------------------
// stm_if - valid/ready channels of the single typo word matcher
// Input channel carries one character beat, output channel one verdict beat.
// ---------------------------------------------------------------------------
interface stm_in_if;
    import stm_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CHAR_W-1:0] char_code;
    logic              char_valid;
    logic              word_last;

    modport source
    (
        output valid, req_type, char_code, char_valid, word_last,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, char_code, char_valid, word_last,
        output ready
    );
endinterface

interface stm_out_if;
    import stm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [VERDICT_W-1:0]    verdict;
    logic [NUM_W-1:0]        candidate_number;
    logic                    is_close;
    logic signed [FCI_W-1:0] first_close_index;
    logic                    length_overflow;

    modport source
    (
        output valid, verdict, candidate_number, is_close, first_close_index,
               length_overflow,
        input  ready
    );

    modport sink
    (
        input  valid, verdict, candidate_number, is_close, first_close_index,
               length_overflow,
        output ready
    );
endinterface

// ----- hdl/stm_front.sv -----
// ---------------------------------------------------------------------------
// stm_front - input front end
// Folds case, tracks word boundaries and lengths, stores the reference word
// and fetches the reference neighbors of each candidate character.
// ---------------------------------------------------------------------------
module stm_front
(
    input  logic           clk,
    input  logic           rst_n,
    stm_in_if.sink         in_ch,
    input  logic           truncate_to_reference,
    output stm_pkg::beat_t beat,
    output logic           beat_valid,
    input  logic           beat_ready
);
    import stm_pkg::*;

    localparam logic REQ_REF = 1'b0;
    localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);
    localparam logic [LEN_W:0]   MAX_LEN_X = (LEN_W + 1)'(MAX_LEN);

    typedef struct packed
    {
        kind_t             kind;
        logic              first;
        logic              last;
        logic              eff;
        logic              adv;
        logic              first_pos;
        logic [CHAR_W-1:0] t;
        logic              in0;
        logic              inp;
        logic              inm;
        logic              len_eq;
        logic              ref_longer;
        logic              cand_longer;
        logic              ovf;
    } stage_t;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = c + 8'h20;
        end
        return v;
    endfunction

    logic [CHAR_W-1:0] ref_mem [MAX_LEN];
    logic [CHAR_W-1:0] rd_reg;

    stage_t            stg_reg, stg_next;
    logic              stg_valid_reg, stg_valid_next;
    logic              ref_open_reg, ref_open_next;
    logic              cand_open_reg, cand_open_next;
    logic              ref_ovf_reg, ref_ovf_next;
    logic              cand_ovf_reg, cand_ovf_next;
    logic [LEN_W-1:0]  ref_len_reg, ref_len_next;
    logic [LEN_W-1:0]  cand_len_reg, cand_len_next;
    logic [CHAR_W-1:0] ref0_reg, ref0_next;
    logic [CHAR_W-1:0] win0_reg, winm_reg;

    logic              accept;
    logic              push;
    logic [CHAR_W-1:0] ch;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [LEN_W-1:0]  ref_base;
    logic [LEN_W-1:0]  cand_pos;
    logic [LEN_W:0]    pos_inc;
    logic              stored;
    logic [LEN_W-1:0]  cand_len_new;
    logic [LEN_W-1:0]  lt_cut;
    logic              in0;
    logic [CHAR_W-1:0] r_cur;

    assign ch          = fold(in_ch.char_code);
    assign in_ch.ready = !stg_valid_reg || beat_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = stg_valid_reg && beat_ready;

    assign ref_base     = ref_open_reg ? ref_len_reg : '0;
    assign cand_pos     = cand_open_reg ? cand_len_reg : '0;
    assign pos_inc      = {1'b0, cand_pos} + (LEN_W + 1)'(1);
    assign stored       = in_ch.char_valid && (cand_pos < MAX_LEN_L);
    assign cand_len_new = cand_pos + LEN_W'(stored);
    assign lt_cut       = (truncate_to_reference && cand_len_new > ref_len_reg) ?
                          ref_len_reg : cand_len_new;
    assign in0          = cand_pos < ref_len_reg;

    always_comb
    begin
        stg_next       = stg_reg;
        stg_valid_next = stg_valid_reg && !push;
        ref_open_next  = ref_open_reg;
        cand_open_next = cand_open_reg;
        ref_ovf_next   = ref_ovf_reg;
        cand_ovf_next  = cand_ovf_reg;
        ref_len_next   = ref_len_reg;
        cand_len_next  = cand_len_reg;
        ref0_next      = ref0_reg;
        wr_en          = 1'b0;
        wr_addr        = ref_base[ADDR_W-1:0];
        rd_en          = 1'b0;
        rd_addr        = pos_inc[ADDR_W-1:0];

        if (accept)
        begin
            if (in_ch.req_type == REQ_REF)
            begin
                cand_open_next = 1'b0;
                ref_open_next  = !in_ch.word_last;
                ref_ovf_next   = ref_open_reg && ref_ovf_reg;
                ref_len_next   = ref_base;
                if (in_ch.char_valid)
                begin
                    if (ref_base < MAX_LEN_L)
                    begin
                        wr_en        = 1'b1;
                        ref_len_next = ref_base + LEN_W'(1);
                        if (ref_base == '0)
                        begin
                            ref0_next = ch;
                        end
                    end
                    else
                    begin
                        ref_ovf_next = 1'b1;
                    end
                end
                stg_next       = '0;
                stg_next.kind  = KIND_REF_START;
                stg_valid_next = !ref_open_reg;
            end
            else
            begin
                ref_open_next  = 1'b0;
                cand_open_next = !in_ch.word_last;
                cand_len_next  = cand_len_new;
                cand_ovf_next  = (cand_open_reg && cand_ovf_reg) ||
                                 (in_ch.char_valid && !stored);
                rd_en          = stored && (pos_inc < MAX_LEN_X);

                stg_next.kind        = KIND_CAND;
                stg_next.first       = !cand_open_reg;
                stg_next.last        = in_ch.word_last;
                stg_next.adv         = stored;
                stg_next.eff         = stored && !(truncate_to_reference && !in0);
                stg_next.first_pos   = cand_pos == '0;
                stg_next.t           = ch;
                stg_next.in0         = in0;
                stg_next.inp         = pos_inc < {1'b0, ref_len_reg};
                stg_next.inm         = (cand_pos != '0) && (cand_pos <= ref_len_reg);
                stg_next.len_eq      = lt_cut == ref_len_reg;
                stg_next.ref_longer  = ({1'b0, lt_cut} + (LEN_W + 1)'(1)) ==
                                       {1'b0, ref_len_reg};
                stg_next.cand_longer = {1'b0, lt_cut} ==
                                       ({1'b0, ref_len_reg} + (LEN_W + 1)'(1));
                stg_next.ovf         = ref_ovf_reg || cand_ovf_next;
                stg_valid_next       = 1'b1;
            end
        end
    end

    assign r_cur = stg_reg.first_pos ? ref0_reg : win0_reg;

    always_comb
    begin
        beat.kind        = stg_reg.kind;
        beat.first       = stg_reg.first;
        beat.last        = stg_reg.last;
        beat.eff         = stg_reg.eff;
        beat.t           = stg_reg.t;
        beat.rm          = winm_reg;
        beat.r0          = r_cur;
        beat.rp          = rd_reg;
        beat.in0         = stg_reg.in0;
        beat.inp         = stg_reg.inp;
        beat.inm         = stg_reg.inm;
        beat.len_eq      = stg_reg.len_eq;
        beat.ref_longer  = stg_reg.ref_longer;
        beat.cand_longer = stg_reg.cand_longer;
        beat.ovf         = stg_reg.ovf;
    end

    assign beat_valid = stg_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            ref_open_reg  <= 1'b0;
            cand_open_reg <= 1'b0;
            ref_ovf_reg   <= 1'b0;
            cand_ovf_reg  <= 1'b0;
            ref_len_reg   <= '0;
            cand_len_reg  <= '0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            ref_open_reg  <= ref_open_next;
            cand_open_reg <= cand_open_next;
            ref_ovf_reg   <= ref_ovf_next;
            cand_ovf_reg  <= cand_ovf_next;
            ref_len_reg   <= ref_len_next;
            cand_len_reg  <= cand_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_reg  <= stg_next;
        ref0_reg <= ref0_next;
        if (push && stg_reg.kind == KIND_CAND && stg_reg.adv)
        begin
            winm_reg <= r_cur;
            win0_reg <= rd_reg;
        end
    end

    // reference store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ref_mem[wr_addr] <= ch;
        end
        if (rd_en)
        begin
            rd_reg <= ref_mem[rd_addr];
        end
    end

endmodule

// ----- hdl/stm_fifo.sv -----
// ---------------------------------------------------------------------------
// stm_fifo - beat queue between front end and back end
// Small synchronous FIFO so either side can stall on its own.
// ---------------------------------------------------------------------------
module stm_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  stm_pkg::beat_t push_beat,
    input  logic           push_valid,
    output logic           push_ready,
    output stm_pkg::beat_t pop_beat,
    output logic           pop_valid,
    input  logic           pop_ready
);
    import stm_pkg::*;

    localparam logic [FIFO_AW:0] DEPTH_L = (FIFO_AW + 1)'(FIFO_DEPTH);

    beat_t              entry [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != DEPTH_L;
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_beat   = entry[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + FIFO_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + FIFO_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (FIFO_AW + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

// ----- hdl/stm_back.sv -----
// ---------------------------------------------------------------------------
// stm_back - comparison back end
// Compares each candidate character on three reference diagonals, tracks
// the first mismatch and classifies the word at its last beat.
// ---------------------------------------------------------------------------
module stm_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  stm_pkg::beat_t beat,
    input  logic           beat_valid,
    output logic           beat_ready,
    stm_out_if.source      out_ch
);
    import stm_pkg::*;

    typedef enum logic [VERDICT_W-1:0]
    {
        V_EXACT,
        V_TRANSPOSE,
        V_SUBST,
        V_EXTRA,
        V_MISSING,
        V_FAR
    } verdict_t;

    logic                    mis_reg, mis_next;
    logic                    just_reg, just_next;
    logic                    sub_ok_reg, sub_ok_next;
    logic                    ext_ok_reg, ext_ok_next;
    logic                    miss_ok_reg, miss_ok_next;
    logic                    trans_ok_reg, trans_ok_next;
    logic [INDEX_BITS-1:0]   cnt_reg, cnt_next;
    logic                    fc_valid_reg, fc_valid_next;
    logic [INDEX_BITS-1:0]   fc_reg, fc_next;

    logic                    out_valid_reg, out_valid_next;
    verdict_t                verdict_reg, verdict_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic                    close_reg, close_next;
    logic signed [FCI_W-1:0] fci_reg, fci_next;
    logic                    ovf_reg, ovf_next;

    logic                    take;
    logic                    mis_b, just_b, sub_b, ext_b, miss_b, trans_b;
    logic                    e0, ep, em, mism, first_mis;

    assign beat_ready = !out_valid_reg || out_ch.ready;
    assign take       = beat_valid && beat_ready;

    assign mis_b   = beat.first ? 1'b0 : mis_reg;
    assign just_b  = beat.first ? 1'b0 : just_reg;
    assign sub_b   = beat.first ? 1'b1 : sub_ok_reg;
    assign ext_b   = beat.first ? 1'b1 : ext_ok_reg;
    assign miss_b  = beat.first ? 1'b1 : miss_ok_reg;
    assign trans_b = beat.first ? 1'b1 : trans_ok_reg;

    assign e0        = beat.in0 && (beat.t == beat.r0);
    assign ep        = beat.inp && (beat.t == beat.rp);
    assign em        = beat.inm && (beat.t == beat.rm);
    assign mism      = !e0;
    assign first_mis = !mis_b && mism;

    always_comb
    begin
        mis_next      = mis_b;
        just_next     = just_b;
        sub_ok_next   = sub_b;
        ext_ok_next   = ext_b;
        miss_ok_next  = miss_b;
        trans_ok_next = trans_b;
        if (beat.eff)
        begin
            mis_next      = mis_b || mism;
            just_next     = first_mis;
            sub_ok_next   = sub_b && !(mis_b && mism);
            ext_ok_next   = ext_b && !((mis_b || mism) && !ep);
            miss_ok_next  = miss_b && !(mis_b && !em);
            trans_ok_next = trans_b && !(first_mis && !ep) && !(just_b && !em) &&
                            !(mis_b && !just_b && mism);
        end
    end

    always_comb
    begin
        if (!mis_next && beat.len_eq)
        begin
            verdict_next = V_EXACT;
        end
        else if (beat.len_eq && trans_ok_next && !just_next)
        begin
            verdict_next = V_TRANSPOSE;
        end
        else if (beat.len_eq && sub_ok_next)
        begin
            verdict_next = V_SUBST;
        end
        else if (beat.ref_longer && ext_ok_next)
        begin
            verdict_next = V_EXTRA;
        end
        else if (beat.cand_longer && miss_ok_next)
        begin
            verdict_next = V_MISSING;
        end
        else
        begin
            verdict_next = V_FAR;
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        fc_valid_next  = fc_valid_reg;
        fc_next        = fc_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        close_next     = verdict_next != V_FAR;
        num_next       = NUM_W'(cnt_reg);
        ovf_next       = beat.ovf;
        if (close_next && !fc_valid_reg)
        begin
            fc_next = cnt_reg;
        end
        fci_next = (fc_valid_reg || close_next) ? FCI_W'(fc_next) : '1;

        if (take)
        begin
            case (beat.kind)
                KIND_REF_START:
                begin
                    cnt_next      = '0;
                    fc_valid_next = 1'b0;
                end
                KIND_CAND:
                begin
                    if (beat.last)
                    begin
                        out_valid_next = 1'b1;
                        cnt_next       = cnt_reg + INDEX_BITS'(1);
                        fc_valid_next  = fc_valid_reg || close_next;
                    end
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            fc_valid_reg  <= 1'b0;
            mis_reg       <= 1'b0;
            just_reg      <= 1'b0;
            sub_ok_reg    <= 1'b1;
            ext_ok_reg    <= 1'b1;
            miss_ok_reg   <= 1'b1;
            trans_ok_reg  <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            fc_valid_reg  <= fc_valid_next;
            if (take && beat.kind == KIND_CAND)
            begin
                mis_reg      <= mis_next;
                just_reg     <= just_next;
                sub_ok_reg   <= sub_ok_next;
                ext_ok_reg   <= ext_ok_next;
                miss_ok_reg  <= miss_ok_next;
                trans_ok_reg <= trans_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fc_reg <= fc_next;
        if (take && beat.kind == KIND_CAND && beat.last)
        begin
            verdict_reg <= verdict_next;
            num_reg     <= num_next;
            close_reg   <= close_next;
            fci_reg     <= fci_next;
            ovf_reg     <= ovf_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.verdict           = verdict_reg;
    assign out_ch.candidate_number  = num_reg;
    assign out_ch.is_close          = close_reg;
    assign out_ch.first_close_index = fci_reg;
    assign out_ch.length_overflow   = ovf_reg;

endmodule

// ----- hdl/single_typo_word_matcher.sv -----
// ---------------------------------------------------------------------------
// single_typo_word_matcher - top level
// Loads a reference word and grades each candidate word against it as exact,
// transposed, substituted, one extra, one missing or far; holds the APB
// configuration register.
// ---------------------------------------------------------------------------
// The block takes one character beat per clock on in_ch, reference and
// candidate characters alike, with no gap between words. Each candidate
// character is compared against the reference characters at the same
// position and its two neighbors; the reference store has one write and
// one registered read port, and the read of the next neighbor is issued
// as the character is accepted. Beats pass the front-end stage register,
// a four-deep beat queue and, for verdicts, an output register; the queue
// separates the input side from the verdict side, so a stalled output
// only holds the input once it is full. Register 0 (truncate_to_reference,
// bit 0, reset 1) is written over APB at byte address 0; the user must
// write it only while no word is in flight; the block does not enforce it.
module single_typo_word_matcher
(
    input  logic                          clk,
    input  logic                          rst_n,
    stm_in_if.sink                        in_ch,
    stm_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stm_pkg::PADDR_W-1:0]   paddr,
    input  logic [stm_pkg::DATA_W-1:0]    pwdata,
    output logic [stm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import stm_pkg::*;

    localparam logic [PADDR_W-3:0] REG_TRUNC = '0;

    logic              trunc_reg, trunc_next;
    logic              cfg_write;
    logic [PADDR_W-3:0] reg_idx;

    beat_t             front_beat, back_beat;
    logic              front_valid, front_ready;
    logic              back_valid, back_ready;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        trunc_next = trunc_reg;
        if (cfg_write && reg_idx == REG_TRUNC)
        begin
            trunc_next = pwdata[0];
        end
        prdata = '0;
        if (reg_idx == REG_TRUNC)
        begin
            prdata = DATA_W'(trunc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trunc_reg <= 1'b1;
        end
        else
        begin
            trunc_reg <= trunc_next;
        end
    end

    stm_front u_front
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_ch                 (in_ch),
        .truncate_to_reference (trunc_reg),
        .beat                  (front_beat),
        .beat_valid            (front_valid),
        .beat_ready            (front_ready)
    );

    stm_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_beat  (front_beat),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_beat   (back_beat),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    stm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (back_beat),
        .beat_valid (back_valid),
        .beat_ready (back_ready),
        .out_ch     (out_ch)
    );

endmodule

// ----- verif/tb_single_typo_word_matcher.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_single_typo_word_matcher - self-checking bench for the word matcher
// Streams reference and candidate words with random gaps and output stalls,
// grades every finished candidate in a local model and compares each verdict
// beat field by field, across both truncation settings.
// ---------------------------------------------------------------------------
module tb_single_typo_word_matcher;
    import stm_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_BEATS   = 350;

    localparam logic [PADDR_W-1:0] TRUNCATE_ADDR = 3'd0;

    typedef enum logic [VERDICT_W-1:0]
    {
        GRADE_EXACT,
        GRADE_SWAP,
        GRADE_SUBST,
        GRADE_EXTRA,
        GRADE_MISSING,
        GRADE_FAR
    } grade_t;

    typedef struct packed
    {
        grade_t             grade;
        logic [NUM_W-1:0]   num;
        logic               close;
        logic [FCI_W-1:0]   first_close;
        logic               ovf;
    } verdict_t;

    typedef logic [CHAR_W-1:0] word_q[$];

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    stm_in_if  in_ch();
    stm_out_if out_ch();

    single_typo_word_matcher u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // grading model state
    logic [CHAR_W-1:0] ref_word  [0:MAX_LEN-1];
    logic [CHAR_W-1:0] cand_word [0:MAX_LEN-1];
    int                ref_len;
    int                cand_len;
    logic [NUM_W-1:0]  cand_count;
    bit                close_seen;
    logic [NUM_W-1:0]  close_num;
    bit                ref_ovf;
    bit                cand_ovf;
    bit                ref_open;
    bit                cand_open;
    bit                trunc_on;

    verdict_t pending_verdicts[$];
    word_q    ref_text;
    word_q    cand_text;

    int err_count     = 0;
    int cycle_count   = 0;
    int beats_counted = 0;
    int total_beats   = 0;
    int verdicts_seen = 0;
    int grade_seen [0:7];
    int hold_cycles   = 0;
    int out_stall     = 0;
    bit snd_quiet     = 1'b0;
    bit rcv_quiet     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles, %0d verdicts outstanding",
                 cycle_count, pending_verdicts.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h (verdict beat %0d, cycle %0d)",
                 what, got, want, verdicts_seen, cycle_count);
        err_count++;
    endtask

    function automatic logic [CHAR_W-1:0] fold_case(logic [CHAR_W-1:0] c);
        if (c >= "A" && c <= "Z")
            return c + 8'h20;
        return c;
    endfunction

    function automatic bit tails_match(int si, int sl, int ti, int tl);
        if (si > sl || ti > tl || sl - si != tl - ti)
            return 1'b0;
        for (int k = 0; si + k < sl; k++)
            if (ref_word[si + k] != cand_word[ti + k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic grade_t grade_pair(int ls, int lt);
        int p;
        p = 0;
        if (tails_match(0, ls, 0, lt))
            return GRADE_EXACT;
        while (p < ls && p < lt && ref_word[p] == cand_word[p])
            p++;
        if (ls - p >= 1)
        begin
            if (lt - p >= 1)
            begin
                if (ls - p >= 2 && lt - p >= 2
                    && ref_word[p] == cand_word[p + 1]
                    && cand_word[p] == ref_word[p + 1]
                    && tails_match(p + 2, ls, p + 2, lt))
                    return GRADE_SWAP;
                if (tails_match(p + 1, ls, p + 1, lt))
                    return GRADE_SUBST;
            end
            if (tails_match(p + 1, ls, p, lt))
                return GRADE_EXTRA;
        end
        if (lt - p >= 1 && tails_match(p, ls, p + 1, lt))
            return GRADE_MISSING;
        return GRADE_FAR;
    endfunction

    function automatic void track_beat(kind_t kind, logic [CHAR_W-1:0] code, bit cv, bit last);
        logic [CHAR_W-1:0] ch;
        int                lt;
        verdict_t          want;
        ch = fold_case(code);
        if (kind == KIND_REF_START)
        begin
            cand_open = 1'b0;
            if (!ref_open)
            begin
                ref_len    = 0;
                cand_count = '0;
                close_seen = 1'b0;
                ref_ovf    = 1'b0;
            end
            if (cv)
            begin
                if (ref_len < MAX_LEN)
                begin
                    ref_word[ref_len] = ch;
                    ref_len++;
                end
                else
                    ref_ovf = 1'b1;
            end
            ref_open = !last;
            return;
        end
        ref_open = 1'b0;
        if (!cand_open)
        begin
            cand_len = 0;
            cand_ovf = 1'b0;
        end
        if (cv)
        begin
            if (cand_len < MAX_LEN)
            begin
                cand_word[cand_len] = ch;
                cand_len++;
            end
            else
                cand_ovf = 1'b1;
        end
        cand_open = !last;
        if (!last)
            return;
        lt = cand_len;
        if (trunc_on && lt > ref_len)
            lt = ref_len;
        want.grade = grade_pair(ref_len, lt);
        want.num   = cand_count;
        want.close = (want.grade != GRADE_FAR);
        if (want.close && !close_seen)
        begin
            close_seen = 1'b1;
            close_num  = cand_count;
        end
        want.first_close = close_seen ? {1'b0, close_num} : '1;
        want.ovf         = ref_ovf || cand_ovf;
        pending_verdicts.push_back(want);
        cand_count++;
    endfunction

    task automatic check_verdict();
        verdict_t want;
        verdicts_seen++;
        if (pending_verdicts.size() == 0)
        begin
            report("verdict beat with nothing pending", 32'(out_ch.candidate_number), 32'd0);
            return;
        end
        want = pending_verdicts.pop_front();
        grade_seen[want.grade]++;
        if (out_ch.verdict !== want.grade)
            report("verdict", 32'(out_ch.verdict), 32'(want.grade));
        if (out_ch.candidate_number !== want.num)
            report("candidate_number", 32'(out_ch.candidate_number), 32'(want.num));
        if (out_ch.is_close !== want.close)
            report("is_close", 32'(out_ch.is_close), 32'(want.close));
        if ($unsigned(out_ch.first_close_index) !== want.first_close)
            report("first_close_index", 32'($unsigned(out_ch.first_close_index)),
                   32'(want.first_close));
        if (out_ch.length_overflow !== want.ovf)
            report("length_overflow", 32'(out_ch.length_overflow), 32'(want.ovf));
    endtask

    // verdict side: per-beat stall, long hold-off on request, checking
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                check_verdict();
                out_stall = rcv_quiet ? 0 : $urandom_range(0, 4);
            end
            if (hold_cycles > 0)
            begin
                out_stall   = hold_cycles;
                hold_cycles = 0;
            end
            if (out_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                out_stall--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_beat(kind_t kind, logic [CHAR_W-1:0] code, bit cv, bit last);
        int gap;
        gap = snd_quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= kind;
        in_ch.char_code  <= code;
        in_ch.char_valid <= cv;
        in_ch.word_last  <= last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        track_beat(kind, code, cv, last);
        total_beats++;
        if (cv || last)
            beats_counted++;
    endtask

    task automatic send_word(kind_t kind, word_q w, bit noisy, bit closed);
        bit blank_end;
        blank_end = closed && (w.size() == 0 || (noisy && $urandom_range(0, 3) == 0));
        foreach (w[i])
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_beat(kind, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(kind, w[i], 1'b1, closed && !blank_end && i == w.size() - 1);
        end
        if (blank_end)
            send_beat(kind, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read(logic [PADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_truncate();
        logic [DATA_W-1:0] rd;
        reg_read(TRUNCATE_ADDR, rd);
        if (rd !== DATA_W'(trunc_on))
            report("truncate_to_reference readback", rd, 32'(trunc_on));
    endtask

    task automatic set_truncate(bit on);
        reg_write(TRUNCATE_ADDR, DATA_W'(on));
        trunc_on = on;
        check_truncate();
    endtask

    function automatic logic [CHAR_W-1:0] shuffle_case(logic [CHAR_W-1:0] c);
        if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 2) == 0)
            return c ^ 8'h20;
        return c;
    endfunction

    // small alphabet so that words collide often; now and then any byte
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(0, 255));
        return shuffle_case(8'("a") + 8'($urandom_range(0, 4)));
    endfunction

    function automatic void pick_reference();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 9);
        ref_text.delete();
        repeat (len) ref_text.push_back(pick_char());
    endfunction

    function automatic void derive_candidate();
        int                n;
        int                p;
        logic [CHAR_W-1:0] c;
        cand_text = ref_text;
        n = cand_text.size();
        case ($urandom_range(0, 7))
            0: ;
            1:
            begin
                if (n >= 2)
                begin
                    p = $urandom_range(0, n - 2);
                    c = cand_text[p];
                    cand_text[p] = cand_text[p + 1];
                    cand_text[p + 1] = c;
                end
            end
            2: if (n >= 1) cand_text[$urandom_range(0, n - 1)] = pick_char();
            3: if (n >= 1) cand_text.delete($urandom_range(0, n - 1));
            4: cand_text.insert($urandom_range(0, n), pick_char());
            5:
            begin
                cand_text.delete();
                repeat ($urandom_range(0, n + 2)) cand_text.push_back(pick_char());
            end
            6: repeat ($urandom_range(1, 4)) cand_text.push_back(pick_char());
            default:
            begin
                if (n >= 1)
                    cand_text[$urandom_range(0, n - 1)] = pick_char();
                if (cand_text.size() >= 1)
                    cand_text.delete($urandom_range(0, cand_text.size() - 1));
            end
        endcase
        foreach (cand_text[i])
            cand_text[i] = shuffle_case(cand_text[i]);
    endfunction

    task automatic run_lists(int goal);
        int stop_at;
        int shape;
        stop_at = beats_counted + goal;
        while (beats_counted < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                snd_quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0)
                rcv_quiet = ($urandom_range(0, 2) == 0);
            shape = $urandom_range(0, 9);
            if (shape == 0)
            begin
                repeat (6)
                    send_beat(kind_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                // shape 1: reference left open, closed by the first candidate
                pick_reference();
                send_word(KIND_REF_START, ref_text, 1'b1, shape != 1);
                repeat ($urandom_range(1, 6))
                begin
                    derive_candidate();
                    send_word(KIND_CAND, cand_text, 1'($urandom_range(0, 1)), 1'b1);
                end
                // shape 2: unfinished candidate, dropped by a following reference or ended by a later candidate beat
                if (shape == 2)
                begin
                    derive_candidate();
                    send_word(KIND_CAND, cand_text, 1'b0, 1'b0);
                end
            end
        end
    endtask

    task automatic test_directed();
        check_truncate();
        send_beat(KIND_REF_START, "A", 1'b1, 1'b0);
        send_beat(KIND_REF_START, "b", 1'b1, 1'b1);
        send_beat(KIND_CAND, "a", 1'b1, 1'b0);
        send_beat(KIND_CAND, "B", 1'b1, 1'b1);
        send_beat(KIND_CAND, "b", 1'b1, 1'b0);
        send_beat(KIND_CAND, "a", 1'b1, 1'b1);
        send_beat(KIND_CAND, "a", 1'b1, 1'b0);
        send_beat(KIND_CAND, "Z", 1'b1, 1'b1);
        send_beat(KIND_CAND, "a", 1'b1, 1'b1);
        send_beat(KIND_CAND, "a", 1'b1, 1'b0);
        send_beat(KIND_CAND, "b", 1'b1, 1'b0);
        send_beat(KIND_CAND, "c", 1'b1, 1'b1);
        send_beat(KIND_CAND, 8'h00, 1'b0, 1'b1);
        send_beat(KIND_CAND, "@", 1'b1, 1'b0);
        send_beat(KIND_CAND, "[", 1'b1, 1'b1);
        send_beat(KIND_CAND, 8'hFF, 1'b1, 1'b0);
        send_beat(KIND_CAND, 8'h00, 1'b1, 1'b1);
        quiesce();
        set_truncate(1'b0);
        send_beat(KIND_CAND, "a", 1'b1, 1'b0);
        send_beat(KIND_CAND, "x", 1'b1, 1'b0);
        send_beat(KIND_CAND, "b", 1'b1, 1'b1);
        send_beat(KIND_REF_START, 8'hFF, 1'b0, 1'b1);
        send_beat(KIND_CAND, 8'hFF, 1'b0, 1'b1);
        quiesce();
    endtask

    task automatic test_overflow();
        ref_text.delete();
        repeat (MAX_LEN + 2) ref_text.push_back(pick_char());
        send_word(KIND_REF_START, ref_text, 1'b0, 1'b1);
        send_word(KIND_CAND, ref_text, 1'b0, 1'b1);
        ref_text.delete();
        repeat (MAX_LEN) ref_text.push_back(pick_char());
        send_word(KIND_REF_START, ref_text, 1'b0, 1'b1);
        cand_text = ref_text;
        cand_text.push_back(pick_char());
        send_word(KIND_CAND, cand_text, 1'b0, 1'b1);
        send_word(KIND_CAND, ref_text, 1'b0, 1'b1);
        quiesce();
    endtask

    task automatic test_backpressure();
        snd_quiet = 1'b1;
        ref_text = '{"a", "b", "c", "d"};
        send_word(KIND_REF_START, ref_text, 1'b0, 1'b1);
        hold_cycles = HOLD_CYCLES;
        repeat (30)
            send_beat(KIND_CAND, 8'("a") + 8'($urandom_range(0, 4)), 1'b1, 1'b1);
        snd_quiet = 1'b0;
        quiesce();
    endtask

    task automatic test_random();
        bit on;
        for (int phase = 0; phase < 4; phase++)
        begin
            on = phase[0];
            send_beat(KIND_CAND, 8'h00, 1'b0, 1'b1);
            quiesce();
            set_truncate(on);
            run_lists(PHASE_BEATS);
        end
        send_beat(KIND_CAND, 8'h00, 1'b0, 1'b1);
        snd_quiet = 1'b0;
        rcv_quiet = 1'b0;
        quiesce();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.req_type   = 1'b0;
        in_ch.char_code  = '0;
        in_ch.char_valid = 1'b0;
        in_ch.word_last  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        ref_len          = 0;
        cand_len         = 0;
        cand_count       = '0;
        close_seen       = 1'b0;
        close_num        = '0;
        ref_ovf          = 1'b0;
        cand_ovf         = 1'b0;
        ref_open         = 1'b0;
        cand_open        = 1'b0;
        trunc_on         = 1'b1;
        foreach (grade_seen[i])
            grade_seen[i] = 0;
        foreach (ref_word[i])
        begin
            ref_word[i]  = '0;
            cand_word[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_backpressure();
        test_random();

        $display("%0d beats, %0d verdicts; exact/swap/subst/extra/missing/far %0d/%0d/%0d/%0d/%0d/%0d",
                 total_beats, verdicts_seen, grade_seen[GRADE_EXACT], grade_seen[GRADE_SWAP],
                 grade_seen[GRADE_SUBST], grade_seen[GRADE_EXTRA], grade_seen[GRADE_MISSING],
                 grade_seen[GRADE_FAR]);
        $display("Both truncation settings, over-long words, %0d-cycle hold-off; %0d errors",
                 HOLD_CYCLES, err_count);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
